>>> rtl/mpba_pkg.sv
// shared constants, pool geometry tables and status codes for the block allocator
`default_nettype none

package mpba_pkg;

    // default sizing
    localparam int NUM_POOLS_DEF = 5;
    localparam int WORD_BITS_DEF = 64;
    localparam int ADDR_BITS_DEF = 48;

    // fixed pool geometry, slots past the fifth are empty
    localparam int POOL_SLOTS = 8;
    localparam int unsigned POOL_BYTES [POOL_SLOTS] =
        '{64, 256, 1024, 4096, 65536, 0, 0, 0};
    localparam int unsigned POOL_LG [POOL_SLOTS] =
        '{6, 8, 10, 12, 16, 0, 0, 0};
    localparam int unsigned POOL_COUNT [POOL_SLOTS] =
        '{16384, 4096, 2048, 1024, 64, 0, 0, 0};
    localparam int unsigned POOL_OFFSET [POOL_SLOTS] =
        '{0, 1048576, 2097152, 4194304, 8388608, 0, 0, 0};
    localparam int unsigned POOL_SPAN [POOL_SLOTS] =
        '{1048576, 1048576, 2097152, 4194304, 4194304, 0, 0, 0};

    // configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PHYS_BASE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VIRT_BASE = 2'd1;

    // request and result codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;
    localparam logic [2:0] ST_ALLOCATED    = 3'd0;
    localparam logic [2:0] ST_ALLOC_FAIL   = 3'd1;
    localparam logic [2:0] ST_FREED        = 3'd2;
    localparam logic [2:0] ST_ALREADY_FREE = 3'd3;
    localparam logic [2:0] ST_INVALID_ADDR = 3'd4;

endpackage

`default_nettype wire

>>> rtl/mpba_div.sv
// iterative restoring remainder unit, one dividend bit per cycle
`default_nettype none

module mpba_div #(
    parameter int DW = 48
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [31:0]   i_divisor,
    output logic               o_done,
    output logic [31:0]        o_remainder
);
    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_dvd;
    logic [31:0]   r_rem;
    logic [31:0]   r_dsr;
    logic [32:0]   w_trial;
    logic [32:0]   w_diff;
    logic          w_ge;

    // trial subtract of the shifted partial remainder
    always_comb begin
        w_trial = {r_rem, r_dvd[DW-1]};
        w_diff  = w_trial - {1'b0, r_dsr};
        w_ge    = (w_trial >= {1'b0, r_dsr});
    end

    // step sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
                r_dvd  <= i_dividend;
                r_rem  <= '0;
                r_dsr  <= i_divisor;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[DW-2:0], w_ge};
                r_rem <= w_ge ? w_diff[31:0] : w_trial[31:0];
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

>>> rtl/multi_pool_bitmap_block_allocator_top.sv
// five-pool bitmap block allocator: sequencer, bitmap memory and use counters
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_stall   | i_op, i_req_size, i_req_alignment,
//          |           |                           | i_req_boundary, i_free_address
//  out     | output    | o_out_valid / i_out_stall | o_status, o_block_address, o_pool_index,
//          |           |                           | o_blk_idx, o_pool_used_count
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// after reset a clearing pass zeroes the bitmap, one word per cycle (369 words at default).
// allocate: pools are selected last to first, and each eligible pool takes four remainder
// divisions, then a scan that tests one block at a time and reads each bitmap word in turn.
// free: pools are tested first to last, then the bitmap word is read and updated.
// a finished result waits in the output register while the next item is accepted.
`default_nettype none

module multi_pool_bitmap_block_allocator_top #(
    parameter int NUM_POOLS = mpba_pkg::NUM_POOLS_DEF,
    parameter int WORD_BITS = mpba_pkg::WORD_BITS_DEF,
    parameter int ADDR_BITS = mpba_pkg::ADDR_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_op,
    input  wire logic [31:0]                       i_req_size,
    input  wire logic [31:0]                       i_req_alignment,
    input  wire logic [31:0]                       i_req_boundary,
    input  wire logic [47:0]                       i_free_address,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [2:0]                             o_status,
    output logic [47:0]                            o_block_address,
    output logic [2:0]                             o_pool_index,
    output logic [13:0]                            o_blk_idx,
    output logic [14:0]                            o_pool_used_count,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [mpba_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [47:0]                       i_cfg_data
);
    import mpba_pkg::*;

    // bitmap layout
    localparam int unsigned WCNT [POOL_SLOTS] = '{
        (POOL_COUNT[0] + WORD_BITS - 1) / WORD_BITS,
        (POOL_COUNT[1] + WORD_BITS - 1) / WORD_BITS,
        (POOL_COUNT[2] + WORD_BITS - 1) / WORD_BITS,
        (POOL_COUNT[3] + WORD_BITS - 1) / WORD_BITS,
        (POOL_COUNT[4] + WORD_BITS - 1) / WORD_BITS,
        (POOL_COUNT[5] + WORD_BITS - 1) / WORD_BITS,
        (POOL_COUNT[6] + WORD_BITS - 1) / WORD_BITS,
        (POOL_COUNT[7] + WORD_BITS - 1) / WORD_BITS};
    localparam int unsigned WBASE [POOL_SLOTS] = '{
        0,
        WCNT[0],
        WCNT[0] + WCNT[1],
        WCNT[0] + WCNT[1] + WCNT[2],
        WCNT[0] + WCNT[1] + WCNT[2] + WCNT[3],
        WCNT[0] + WCNT[1] + WCNT[2] + WCNT[3] + WCNT[4],
        WCNT[0] + WCNT[1] + WCNT[2] + WCNT[3] + WCNT[4] + WCNT[5],
        WCNT[0] + WCNT[1] + WCNT[2] + WCNT[3] + WCNT[4] + WCNT[5] + WCNT[6]};
    localparam int unsigned DEPTH = WBASE[7] + WCNT[7];
    localparam int AW = $clog2(DEPTH);
    localparam int BW = $clog2(WORD_BITS);
    localparam int EW = ((ADDR_BITS > 48) ? ADDR_BITS : 48) + 1;

    // sequencer states
    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_ASEL = 4'd2;
    localparam logic [3:0] S_DPA  = 4'd3;
    localparam logic [3:0] S_DPB  = 4'd4;
    localparam logic [3:0] S_DSA  = 4'd5;
    localparam logic [3:0] S_DSB  = 4'd6;
    localparam logic [3:0] S_ARD  = 4'd7;
    localparam logic [3:0] S_ACHK = 4'd8;
    localparam logic [3:0] S_FSEL = 4'd9;
    localparam logic [3:0] S_FRD  = 4'd10;
    localparam logic [3:0] S_FCHK = 4'd11;

    logic [3:0]           r_state;
    logic [AW-1:0]        r_clr_addr;
    logic [47:0]          r_phys;
    logic [47:0]          r_virt;
    logic [31:0]          r_size;
    logic [31:0]          r_align;
    logic [31:0]          r_bound;
    logic [47:0]          r_faddr;
    logic [2:0]           r_pool;
    logic [ADDR_BITS-1:0] r_bp;
    logic [ADDR_BITS-1:0] r_vp;
    logic [31:0]          r_ra;
    logic [31:0]          r_rb;
    logic [31:0]          r_sa;
    logic [31:0]          r_sb;
    logic [14:0]          r_blk;
    logic [BW-1:0]        r_bit;
    logic [AW-1:0]        r_waddr;
    logic [14:0]          r_used_cnt [POOL_SLOTS];
    logic [WORD_BITS-1:0] r_bitmap [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;
    logic                 r_out_valid;
    logic [2:0]           r_out_status;
    logic [47:0]          r_out_addr;
    logic [2:0]           r_out_pool;
    logic [13:0]          r_out_blk;
    logic [14:0]          r_out_cnt;

    logic [16:0]          w_bs;
    logic [14:0]          w_count;
    logic [AW-1:0]        w_base;
    logic [EW-1:0]        w_pb_e;
    logic [EW-1:0]        w_vb_e;
    logic [ADDR_BITS-1:0] w_pb;
    logic [ADDR_BITS-1:0] w_vb;
    logic [EW-1:0]        w_vb_z;
    logic [EW-1:0]        w_vend;
    logic [EW-1:0]        w_faddr_e;
    logic [EW-1:0]        w_foff;
    logic [EW-1:0]        w_fsh;
    logic [14:0]          w_fj;
    logic                 w_fhit;
    logic                 w_elig;
    logic                 w_out_free;
    logic                 w_out_load;
    logic [WORD_BITS-1:0] w_mask;
    logic                 w_bit;
    logic                 w_bok;
    logic                 w_ok;
    logic                 w_last;
    logic [ADDR_BITS:0]   w_next_bp;
    logic [32:0]          w_ra_sum;
    logic [32:0]          w_rb_sum;
    logic [31:0]          w_ra_n;
    logic [31:0]          w_rb_n;
    logic [31:0]          w_al_raw;
    logic [31:0]          w_al;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [WORD_BITS-1:0] w_wdata;
    logic                 w_div_start;
    logic [ADDR_BITS-1:0] w_div_dvd;
    logic [31:0]          w_div_dsr;
    logic                 w_div_done;
    logic [31:0]          w_div_rem;

    // pool table lookups and address ranges
    always_comb begin
        w_bs      = 17'(POOL_BYTES[r_pool]);
        w_count   = 15'(POOL_COUNT[r_pool]);
        w_base    = AW'(WBASE[r_pool]);
        w_pb_e    = EW'(r_phys) + EW'(POOL_OFFSET[r_pool]);
        w_vb_e    = EW'(r_virt) + EW'(POOL_OFFSET[r_pool]);
        w_pb      = w_pb_e[ADDR_BITS-1:0];
        w_vb      = w_vb_e[ADDR_BITS-1:0];
        w_vb_z    = EW'(w_vb);
        w_vend    = w_vb_z + EW'(POOL_SPAN[r_pool]);
        w_faddr_e = EW'(r_faddr);
        w_foff    = w_faddr_e - w_vb_z;
        w_fsh     = w_foff >> POOL_LG[r_pool];
        w_fj      = w_fsh[14:0];
        w_fhit    = (w_bs != 17'd0) && (w_faddr_e >= w_vb_z) && (w_faddr_e < w_vend);
        w_elig    = (r_size <= 32'(w_bs)) && (r_align <= 32'(w_bs));
    end

    // candidate block test and residue stepping
    always_comb begin
        w_out_free = !r_out_valid || !i_out_stall;
        w_mask     = WORD_BITS'(1) << r_bit;
        w_bit      = r_rdata[r_bit];
        if (r_size == 32'd0) begin
            w_bok = (r_rb != 32'd0);
        end else begin
            w_bok = (({1'b0, r_rb} + {1'b0, r_size - 32'd1}) < {1'b0, r_bound});
        end
        w_ok      = !w_bit && (r_ra == 32'd0) && w_bok;
        w_last    = ((r_blk + 15'd1) == w_count);
        w_next_bp = {1'b0, r_bp} + (ADDR_BITS+1)'(w_bs);
        w_ra_sum  = {1'b0, r_ra} + {1'b0, r_sa};
        w_rb_sum  = {1'b0, r_rb} + {1'b0, r_sb};
        w_ra_n    = (w_ra_sum >= {1'b0, r_align}) ? 32'(w_ra_sum - {1'b0, r_align})
                                                  : w_ra_sum[31:0];
        w_rb_n    = (w_rb_sum >= {1'b0, r_bound}) ? 32'(w_rb_sum - {1'b0, r_bound})
                                                  : w_rb_sum[31:0];
        w_al_raw  = (i_req_alignment < i_req_size) ? i_req_size : i_req_alignment;
        w_al      = (w_al_raw == 32'd0) ? 32'd1 : w_al_raw;
    end

    // result register load
    always_comb begin
        unique case (r_state)
            S_ASEL: begin
                w_out_load = w_out_free && !(r_bound != 32'd0 && w_elig)
                             && (r_bound == 32'd0 || r_pool == 3'd0);
            end
            S_ACHK: begin
                w_out_load = w_out_free && (w_ok || (w_last && r_pool == 3'd0));
            end
            S_FSEL: begin
                w_out_load = w_out_free && !w_fhit && (r_pool == 3'(NUM_POOLS - 1));
            end
            S_FCHK: begin
                w_out_load = w_out_free;
            end
            default: begin
                w_out_load = 1'b0;
            end
        endcase
    end

    // shared divider operand selection
    always_comb begin
        w_div_start = 1'b0;
        w_div_dvd   = '0;
        w_div_dsr   = r_align;
        unique case (r_state)
            S_ASEL: begin
                w_div_dvd   = w_pb;
                w_div_start = (r_bound != 32'd0) && w_elig;
            end
            S_DPA: begin
                w_div_dvd   = r_bp;
                w_div_dsr   = r_bound;
                w_div_start = w_div_done;
            end
            S_DPB: begin
                w_div_dvd   = ADDR_BITS'(w_bs);
                w_div_start = w_div_done;
            end
            S_DSA: begin
                w_div_dvd   = ADDR_BITS'(w_bs);
                w_div_dsr   = r_bound;
                w_div_start = w_div_done;
            end
            S_ACHK: begin
                w_div_dvd   = w_next_bp[ADDR_BITS-1:0];
                w_div_start = !w_ok && !w_last && w_next_bp[ADDR_BITS];
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    mpba_div #(
        .DW(ADDR_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_div_dvd),
        .i_divisor   (w_div_dsr),
        .o_done      (w_div_done),
        .o_remainder (w_div_rem)
    );

    // bitmap write port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_waddr;
        w_wdata = r_rdata;
        if (r_state == S_CLR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
        end else if (r_state == S_ACHK && w_ok && w_out_free) begin
            w_we    = 1'b1;
            w_wdata = r_rdata | w_mask;
        end else if (r_state == S_FCHK && w_bit && w_out_free) begin
            w_we    = 1'b1;
            w_wdata = r_rdata & ~w_mask;
        end
    end

    // bitmap memory, read every cycle at the current word
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_bitmap[w_waddr] <= w_wdata;
        end
        r_rdata <= r_bitmap[r_waddr];
    end

    // sequencer, counters, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_phys      <= '0;
            r_virt      <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < POOL_SLOTS; k++) begin
                r_used_cnt[k] <= '0;
            end
        end else begin
            // configuration writes
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_PHYS_BASE) begin
                    r_phys <= i_cfg_data;
                end else if (i_cfg_index == CFG_VIRT_BASE) begin
                    r_virt <= i_cfg_data;
                end
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_size  <= i_req_size;
                        r_align <= w_al;
                        r_bound <= i_req_boundary;
                        r_faddr <= i_free_address;
                        if (i_op == OP_FREE) begin
                            r_pool  <= 3'd0;
                            r_state <= S_FSEL;
                        end else begin
                            r_pool  <= 3'(NUM_POOLS - 1);
                            r_state <= S_ASEL;
                        end
                    end
                end
                // pick the next pool, last to first
                S_ASEL: begin
                    if (r_bound != 32'd0 && w_elig) begin
                        r_bp    <= w_pb;
                        r_vp    <= w_vb;
                        r_blk   <= '0;
                        r_bit   <= '0;
                        r_waddr <= w_base;
                        r_state <= S_DPA;
                    end else if (r_bound == 32'd0 || r_pool == 3'd0) begin
                        if (w_out_free) begin
                            r_out_status <= ST_ALLOC_FAIL;
                            r_out_addr   <= '0;
                            r_out_pool   <= '0;
                            r_out_blk    <= '0;
                            r_out_cnt    <= '0;
                            r_state      <= S_IDLE;
                        end
                    end else begin
                        r_pool <= r_pool - 3'd1;
                    end
                end
                // starting residues of address and step
                S_DPA: begin
                    if (w_div_done) begin
                        r_ra    <= w_div_rem;
                        r_state <= S_DPB;
                    end
                end
                S_DPB: begin
                    if (w_div_done) begin
                        r_rb    <= w_div_rem;
                        r_state <= S_DSA;
                    end
                end
                S_DSA: begin
                    if (w_div_done) begin
                        r_sa    <= w_div_rem;
                        r_state <= S_DSB;
                    end
                end
                S_DSB: begin
                    if (w_div_done) begin
                        r_sb    <= w_div_rem;
                        r_state <= S_ARD;
                    end
                end
                S_ARD: begin
                    r_state <= S_ACHK;
                end
                // one candidate block per cycle, but for bitmap word reads, residues taken again and output stalls
                S_ACHK: begin
                    if (w_ok) begin
                        if (w_out_free) begin
                            r_used_cnt[r_pool] <= r_used_cnt[r_pool] + 15'd1;
                            r_out_status <= ST_ALLOCATED;
                            r_out_addr   <= 48'(r_vp);
                            r_out_pool   <= r_pool;
                            r_out_blk    <= r_blk[13:0];
                            r_out_cnt    <= r_used_cnt[r_pool] + 15'd1;
                            r_state      <= S_IDLE;
                        end
                    end else if (w_last) begin
                        if (r_pool != 3'd0) begin
                            r_pool  <= r_pool - 3'd1;
                            r_state <= S_ASEL;
                        end else if (w_out_free) begin
                            r_out_status <= ST_ALLOC_FAIL;
                            r_out_addr   <= '0;
                            r_out_pool   <= '0;
                            r_out_blk    <= '0;
                            r_out_cnt    <= '0;
                            r_state      <= S_IDLE;
                        end
                    end else begin
                        r_blk <= r_blk + 15'd1;
                        r_vp  <= r_vp + ADDR_BITS'(w_bs);
                        r_bp  <= w_next_bp[ADDR_BITS-1:0];
                        if (r_bit == BW'(WORD_BITS - 1)) begin
                            r_bit   <= '0;
                            r_waddr <= r_waddr + AW'(1);
                        end else begin
                            r_bit <= r_bit + BW'(1);
                        end
                        if (w_next_bp[ADDR_BITS]) begin
                            // address wrapped, residues taken again
                            r_state <= S_DPA;
                        end else begin
                            r_ra <= w_ra_n;
                            r_rb <= w_rb_n;
                            if (r_bit == BW'(WORD_BITS - 1)) begin
                                r_state <= S_ARD;
                            end
                        end
                    end
                end
                // find the pool holding the address, first to last
                S_FSEL: begin
                    if (w_fhit) begin
                        r_blk   <= w_fj;
                        r_waddr <= w_base + AW'(w_fj >> BW);
                        r_bit   <= w_fj[BW-1:0];
                        r_state <= S_FRD;
                    end else if (r_pool == 3'(NUM_POOLS - 1)) begin
                        if (w_out_free) begin
                            r_out_status <= ST_INVALID_ADDR;
                            r_out_addr   <= '0;
                            r_out_pool   <= '0;
                            r_out_blk    <= '0;
                            r_out_cnt    <= '0;
                            r_state      <= S_IDLE;
                        end
                    end else begin
                        r_pool <= r_pool + 3'd1;
                    end
                end
                S_FRD: begin
                    r_state <= S_FCHK;
                end
                S_FCHK: begin
                    if (w_out_free) begin
                        r_out_addr  <= '0;
                        r_out_pool  <= r_pool;
                        r_out_blk   <= r_blk[13:0];
                        if (w_bit) begin
                            r_used_cnt[r_pool] <= r_used_cnt[r_pool] - 15'd1;
                            r_out_status <= ST_FREED;
                            r_out_cnt    <= r_used_cnt[r_pool] - 15'd1;
                        end else begin
                            r_out_status <= ST_ALREADY_FREE;
                            r_out_cnt    <= r_used_cnt[r_pool];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_cfg_ready       = 1'b1;
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_block_address   = r_out_addr;
    assign o_pool_index      = r_out_pool;
    assign o_blk_idx         = r_out_blk;
    assign o_pool_used_count = r_out_cnt;

endmodule

`default_nettype wire

>>> rtl/mpba_chk.sv
// port-level checker for the block allocator, bound to the top level
`default_nettype none

module mpba_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [2:0]  o_status,
    input wire logic [47:0] o_block_address,
    input wire logic [2:0]  o_pool_index,
    input wire logic [13:0] o_blk_idx,
    input wire logic [14:0] o_pool_used_count
);
    import mpba_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_block_address) && $stable(o_pool_used_count))
        else $error("stalled result changed");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("accepted a second item back to back");

    // failures carry zero payload
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_ALLOC_FAIL || o_status == ST_INVALID_ADDR)
            |-> o_block_address == 48'd0 && o_pool_index == 3'd0
                && o_blk_idx == 14'd0 && o_pool_used_count == 15'd0)
        else $error("failure result with nonzero payload");

    // frees never return an address
    a_free_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FREED || o_status == ST_ALREADY_FREE)
            |-> o_block_address == 48'd0)
        else $error("free result with an address");

endmodule

bind multi_pool_bitmap_block_allocator_top mpba_chk u_mpba_chk (.*);

`default_nettype wire

>>> sim/multi_pool_bitmap_block_allocator_top_tb.sv
// self-checking testbench for the multi-pool bitmap block allocator
`default_nettype none

module multi_pool_bitmap_block_allocator_top_tb;
    import mpba_pkg::*;

    localparam int NPOOL = NUM_POOLS_DEF;
    localparam longint unsigned AMASK = 64'h0000_FFFF_FFFF_FFFF;
    localparam int LIMIT = 10000000;
    localparam int HOLD_CYCLES = 2000;

    typedef struct {
        logic        op;
        logic [31:0] size;
        logic [31:0] align;
        logic [31:0] bound;
        logic [47:0] faddr;
    } req_t;

    typedef struct {
        logic [2:0]  st;
        logic [47:0] addr;
        logic [2:0]  pool;
        logic [13:0] blk;
        logic [14:0] cnt;
    } res_t;

    typedef struct {
        int pool;
        int blk;
    } blk_ref_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        i_op = 1'b0;
    logic [31:0] i_req_size = '0;
    logic [31:0] i_req_alignment = '0;
    logic [31:0] i_req_boundary = '0;
    logic [47:0] i_free_address = '0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [47:0] i_cfg_data = '0;
    wire logic        o_in_stall;
    wire logic        o_out_valid;
    wire logic [2:0]  o_status;
    wire logic [47:0] o_block_address;
    wire logic [2:0]  o_pool_index;
    wire logic [13:0] o_blk_idx;
    wire logic [14:0] o_pool_used_count;
    wire logic        o_cfg_ready;

    multi_pool_bitmap_block_allocator_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_op(i_op), .i_req_size(i_req_size), .i_req_alignment(i_req_alignment),
        .i_req_boundary(i_req_boundary), .i_free_address(i_free_address),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_status(o_status), .o_block_address(o_block_address),
        .o_pool_index(o_pool_index), .o_blk_idx(o_blk_idx),
        .o_pool_used_count(o_pool_used_count),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // predicted allocator state
    bit              used_map [NPOOL][16384];
    logic [14:0]     used_cnt [NPOOL];
    longint unsigned pred_phys;
    longint unsigned pred_virt;

    req_t     alloc_req_q [$];
    res_t     result_q [$];
    blk_ref_t live_blks [$];
    blk_ref_t freed_blks [$];

    int  errors = 0;
    int  cycles = 0;
    int  send_idle = 0;
    int  recv_stall = 0;
    bit  hold_arm = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // computes the result of one request and updates the predicted bitmap
    function automatic res_t allocate_or_release(req_t r);
        res_t            o;
        longint unsigned size, align, bound, fa, bs, pb, vb, bp, j;
        o = '{default: '0};
        size  = r.size;
        align = r.align;
        bound = r.bound;
        fa    = r.faddr;
        if (r.op == OP_ALLOC) begin
            o.st = ST_ALLOC_FAIL;
            if (bound == 0) return o;
            if (align < size) align = size;
            if (align == 0) align = 1;
            for (int p = NPOOL - 1; p >= 0; p--) begin
                bs = POOL_BYTES[p];
                if (size > bs || align > bs) continue;
                pb = (pred_phys + POOL_OFFSET[p]) & AMASK;
                vb = (pred_virt + POOL_OFFSET[p]) & AMASK;
                for (j = 0; j < POOL_COUNT[p]; j++) begin
                    if (used_map[p][j]) continue;
                    bp = (pb + j * bs) & AMASK;
                    if (bp % align == 0 && bp / bound == (bp + size - 1) / bound) begin
                        used_map[p][j] = 1'b1;
                        used_cnt[p] = 15'(used_cnt[p] + 15'd1);
                        o.st   = ST_ALLOCATED;
                        o.addr = 48'((vb + j * bs) & AMASK);
                        o.pool = 3'(p);
                        o.blk  = 14'(j);
                        o.cnt  = used_cnt[p];
                        return o;
                    end
                end
            end
            return o;
        end
        // release: first pool whose range holds the address, no wrap on the test
        for (int p = 0; p < NPOOL; p++) begin
            bs = POOL_BYTES[p];
            vb = (pred_virt + POOL_OFFSET[p]) & AMASK;
            if (fa < vb || fa >= vb + bs * POOL_COUNT[p]) continue;
            j = (fa - vb) / bs;
            o.pool = 3'(p);
            o.blk  = 14'(j);
            if (used_map[p][j]) begin
                used_map[p][j] = 1'b0;
                used_cnt[p] = 15'(used_cnt[p] - 15'd1);
                o.st = ST_FREED;
            end else begin
                o.st = ST_ALREADY_FREE;
            end
            o.cnt = used_cnt[p];
            return o;
        end
        o.st = ST_INVALID_ADDR;
        return o;
    endfunction

    function automatic logic [47:0] blk_vaddr(blk_ref_t b);
        longint unsigned a;
        a = pred_virt + POOL_OFFSET[b.pool] + longint'(b.blk) * POOL_BYTES[b.pool];
        return a[47:0];
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycles);
        errors++;
    endtask

    // predict an item, queue it and track live blocks
    task automatic queue_item(req_t r);
        res_t     e;
        blk_ref_t b;
        e = allocate_or_release(r);
        alloc_req_q.insert(alloc_req_q.size(), r);
        result_q.insert(result_q.size(), e);
        b.pool = int'(e.pool);
        b.blk  = int'(e.blk);
        if (e.st == ST_ALLOCATED) begin
            live_blks.insert(live_blks.size(), b);
        end else if (e.st == ST_FREED) begin
            foreach (live_blks[k]) begin
                if (live_blks[k].pool == b.pool && live_blks[k].blk == b.blk) begin
                    live_blks.delete(k);
                    break;
                end
            end
            freed_blks.insert(freed_blks.size(), b);
            if (freed_blks.size() > 16) void'(freed_blks.pop_front());
        end
    endtask

    task automatic queue_alloc(logic [31:0] s, logic [31:0] a, logic [31:0] b);
        req_t r;
        r = '{op: OP_ALLOC, size: s, align: a, bound: b, faddr: 48'({$urandom, $urandom})};
        queue_item(r);
    endtask

    task automatic queue_free(logic [47:0] fa);
        req_t r;
        r = '{op: OP_FREE, size: $urandom, align: $urandom, bound: $urandom, faddr: fa};
        queue_item(r);
    endtask

    // random requests; rough mode keeps alignment trivial for unaligned bases
    task automatic queue_random(int n, bit rough);
        logic [31:0] s, a, b;
        logic [47:0] fa;
        blk_ref_t    br;
        int          alloc_pct;
        for (int i = 0; i < n; i++) begin
            alloc_pct = (live_blks.size() > 40) ? 25 : 60;
            if ($urandom_range(99) < alloc_pct) begin
                case ($urandom_range(9))
                    0: s = 0;
                    1, 2, 3, 4: s = $urandom_range(1, 4096);
                    5, 6: s = 32'd1 << $urandom_range(0, 16);
                    7: s = $urandom_range(4097, 65536);
                    8: s = $urandom;
                    default: s = $urandom_range(1, 64);
                endcase
                case ($urandom_range(19))
                    0, 1, 2, 3, 4, 5, 6, 7: a = 0;
                    8, 9, 10, 11, 12, 13, 14, 15, 16: a = 32'd1 << $urandom_range(0, 16);
                    default: a = $urandom;
                endcase
                case ($urandom_range(99))
                    0, 1, 2: b = 0;
                    3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19: b = $urandom;
                    default: b = 32'd1 << $urandom_range(16, 31);
                endcase
                if (rough) begin
                    s = $urandom_range(0, 1);
                    a = $urandom_range(0, 1);
                end
                queue_alloc(s, a, b);
            end else begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: begin
                        if (live_blks.size() != 0) begin
                            br = live_blks[$urandom_range(live_blks.size() - 1)];
                            fa = blk_vaddr(br) + $urandom_range(0, POOL_BYTES[br.pool] - 1);
                        end else begin
                            fa = 48'({$urandom, $urandom});
                        end
                    end
                    5, 6: begin
                        if (freed_blks.size() != 0)
                            fa = blk_vaddr(freed_blks[$urandom_range(freed_blks.size() - 1)]);
                        else
                            fa = pred_virt[47:0] + $urandom_range(0, 12 * 1048576);
                    end
                    7: fa = 48'({$urandom, $urandom});
                    default: fa = pred_virt[47:0] + $urandom_range(0, 12 * 1048576);
                endcase
                queue_free(fa);
            end
        end
    endtask

    // register write on the configuration channel
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [47:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_PHYS_BASE) pred_phys = val;
        else pred_virt = val;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (alloc_req_q.size() != 0 || result_q.size() != 0);
        repeat (50) @(negedge i_clk);
    endtask

    task automatic run_phase(logic [47:0] pb, logic [47:0] vb, int idle, int stall,
                             int n, bit rough, bit directed, bit pressure);
        blk_ref_t br;
        write_reg(CFG_PHYS_BASE, pb);
        write_reg(CFG_VIRT_BASE, vb);
        @(negedge i_clk);
        send_idle  = idle;
        recv_stall = stall;
        if (directed) begin
            queue_alloc(0, 0, 0);
            queue_alloc(0, 0, 32'hFFFF_FFFF);
            queue_alloc(1, 1, 1);
            queue_alloc(65536, 0, 32'h8000_0000);
            queue_alloc(65537, 0, 32'hFFFF_FFFF);
            queue_alloc(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            queue_alloc(32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
            queue_alloc(64, 64, 64);
            queue_alloc(4096, 4096, 4096);
            queue_alloc(48, 0, 32'hFFFF_FFFF);
            queue_alloc(100, 32, 128);
            queue_alloc(0, 0, 1);
            br = live_blks[0];
            queue_free(blk_vaddr(br));
            queue_free(blk_vaddr(br));
            queue_free(48'h0);
            queue_free(48'hFFFF_FFFF_FFFF);
            queue_free(48'd12 * 1048576);
            queue_free(48'd12 * 1048576 - 1);
            queue_free(48'd1048576);
        end
        queue_random(n, rough);
        if (pressure) hold_arm = 1'b1;
        wait_drained();
    endtask

    // stimulus sequence
    initial begin
        foreach (used_cnt[p]) used_cnt[p] = '0;
        pred_phys = 0;
        pred_virt = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_phase(48'h0, 48'h0, 0, 0, 210, 1'b0, 1'b1, 1'b0);
        run_phase(48'h1234_5678_0000, 48'h0000_ABCD_0000, 55, 0, 230, 1'b0, 1'b0, 1'b1);
        run_phase(48'hFFFF_FFFF_0000, 48'hFFFF_FFFF_0000, 0, 55, 230, 1'b0, 1'b0, 1'b0);
        run_phase(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 27, 27, 230, 1'b1, 1'b0, 1'b0);
        run_phase(48'h0, 48'h0, 27, 27, 230, 1'b0, 1'b0, 1'b0);
        run_phase({$urandom, 16'h0} & 48'hFFFF_FFFF_0000, {$urandom, 16'h0}, 0, 0, 230,
                  1'b0, 1'b0, 1'b0);
        repeat (100) @(negedge i_clk);
        if (errors == 0)
            $display("PASS multi_pool_bitmap_block_allocator_top");
        else
            $display("FAIL multi_pool_bitmap_block_allocator_top");
        $finish;
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) void'(alloc_req_q.pop_front());
            if (i_in_valid && o_in_stall) begin
                // hold the stalled item
            end else if (alloc_req_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                i_in_valid      <= 1'b1;
                i_op            <= alloc_req_q[0].op;
                i_req_size      <= alloc_req_q[0].size;
                i_req_alignment <= alloc_req_q[0].align;
                i_req_boundary  <= alloc_req_q[0].bound;
                i_free_address  <= alloc_req_q[0].faddr;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_arm && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor, receiver stall and timeout
    always @(posedge i_clk) begin
        res_t e;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL multi_pool_bitmap_block_allocator_top");
            $finish;
        end else begin
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected item status", o_status, 0);
                end else begin
                    e = result_q.pop_front();
                    if (o_status !== e.st) report_mismatch("status", o_status, e.st);
                    if (o_block_address !== e.addr)
                        report_mismatch("block_address", o_block_address, e.addr);
                    if (o_pool_index !== e.pool)
                        report_mismatch("pool_index", o_pool_index, e.pool);
                    if (o_blk_idx !== e.blk)
                        report_mismatch("block number", o_blk_idx, e.blk);
                    if (o_pool_used_count !== e.cnt)
                        report_mismatch("pool_used_count", o_pool_used_count, e.cnt);
                end
            end
            i_out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall);
        end
    end

endmodule

`default_nettype wire
